[src/pdd_pkg.sv]
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types, constants and helpers for the playfair digraph decrypter.
// ----------------------------------------------------------------------------
package pdd_pkg;

  localparam int SIDE   = 5;
  localparam int CODE_W = 5;
  localparam int CELLS  = SIDE * SIDE;
  localparam int ROW_W  = SIDE * CODE_W;
  localparam int POS_W  = 3;
  localparam int IDX_W  = 3;

  localparam logic [CODE_W-1:0] CODE_I = 5'd8;
  localparam logic [CODE_W-1:0] CODE_J = 5'd9;

  localparam logic [IDX_W-1:0] REG_KEY_ROW_0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY_ROW_1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY_ROW_2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEY_ROW_3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_KEY_ROW_4 = 3'd4;

  localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_LAST  = 3'd4;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SIDE-1:0][ROW_W-1:0] square_t;

  typedef struct packed {
    logic [CELLS-1:0] hit_first;
    logic [CELLS-1:0] hit_second;
  } hit_t;

  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } loc_t;

  function automatic code_t map_code(input code_t code);
    map_code = (code == CODE_J) ? CODE_I : code;
  endfunction

  function automatic code_t cell_at(input square_t sq, input pos_t r, input pos_t c);
    logic [ROW_W-1:0] row;
    row = sq[r];
    cell_at = row[c*CODE_W +: CODE_W];
  endfunction

  // first hit in row-major order
  function automatic loc_t first_hit(input logic [CELLS-1:0] hit);
    loc_t loc;
    loc = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (hit[r*SIDE + c]) begin
          loc.found = 1'b1;
          loc.row   = POS_W'(r);
          loc.col   = POS_W'(c);
        end
      end
    end
    first_hit = loc;
  endfunction

  function automatic pos_t dec_wrap(input pos_t p);
    dec_wrap = (p == POS_FIRST) ? POS_LAST : pos_t'(p - 1'b1);
  endfunction

endpackage

[src/playfair_digraph_decrypt_top.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_top
// Playfair digraph decryption against a 5x5 key square.
// ----------------------------------------------------------------------------
// Takes ciphertext digraphs: 25 compare lanes, one per key cell, register their
// hits, then a merge stage picks the first match of each letter in row-major
// order, applies the same-row, same-column or rectangle rule and registers the
// result. J is looked up as I. If either letter is missing from the square,
// tuser is set and both plaintext letters are zero. Both stages advance together
// whenever the output register is empty or being taken, so the throughput is one
// item per cycle. The user must write key rows through the cfg port only while
// no item is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module playfair_digraph_decrypt_top
  import pdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [ROW_W-1:0]   cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // cipher_first, cipher_second, zero pad
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // plain_first, plain_second, zero pad
  output logic               m_axis_tuser   // not_found
);

  square_t     square;
  hit_t        hits;
  hit_t        hits_next;
  logic        hit_valid;
  logic        out_valid;
  code_t       out_first;
  code_t       out_second;
  logic        out_nf;
  code_t       code_first;
  code_t       code_second;
  code_t       merge_first;
  code_t       merge_second;
  logic        merge_nf;
  logic        advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      square <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_ROW_0: square[0] <= cfg_data;
        REG_KEY_ROW_1: square[1] <= cfg_data;
        REG_KEY_ROW_2: square[2] <= cfg_data;
        REG_KEY_ROW_3: square[3] <= cfg_data;
        REG_KEY_ROW_4: square[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = advance;

  assign code_first  = map_code(s_axis_tdata[CODE_W-1:0]);
  assign code_second = map_code(s_axis_tdata[2*CODE_W-1:CODE_W]);

  for (genvar r = 0; r < SIDE; r++) begin : g_row
    for (genvar c = 0; c < SIDE; c++) begin : g_col
      logic [1:0] lane_hit;
      pdd_lane u_lane (
        .key_code    (square[r][c*CODE_W +: CODE_W]),
        .code_first  (code_first),
        .code_second (code_second),
        .hit         (lane_hit)
      );
      assign hits_next.hit_first[r*SIDE + c]  = lane_hit[0];
      assign hits_next.hit_second[r*SIDE + c] = lane_hit[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (advance) begin
      hit_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hits <= hits_next;
    end
  end

  pdd_merge u_merge (
    .hits         (hits),
    .square       (square),
    .plain_first  (merge_first),
    .plain_second (merge_second),
    .not_found    (merge_nf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_first  <= merge_first;
      out_second <= merge_second;
      out_nf     <= merge_nf;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_second, out_first};
  assign m_axis_tuser  = out_nf;

`ifndef SYNTH
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_nf |-> (out_first == '0) && (out_second == '0))
    else $error("not-found item carries nonzero letters");

  a_hit_to_out: assert property (@(posedge clk) disable iff (rst)
    hit_valid && advance |=> out_valid)
    else $error("lane hits lost before output register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !hit_valid)
    else $error("pipeline valid set right after reset");
`endif

endmodule

[src/pdd_lane.sv]
// ----------------------------------------------------------------------------
// pdd_lane
// One key-square cell: compares its letter against both looked-up codes.
// ----------------------------------------------------------------------------
module pdd_lane
  import pdd_pkg::*;
(
  input  code_t      key_code,
  input  code_t      code_first,
  input  code_t      code_second,
  output logic [1:0] hit
);

  assign hit[0] = (key_code == code_first);
  assign hit[1] = (key_code == code_second);

endmodule

[src/pdd_merge.sv]
// ----------------------------------------------------------------------------
// pdd_merge
// Combines the lane hits: picks the first match per letter and applies the
// row, column and rectangle rules.
// ----------------------------------------------------------------------------
module pdd_merge
  import pdd_pkg::*;
(
  input  hit_t    hits,
  input  square_t square,
  output code_t   plain_first,
  output code_t   plain_second,
  output logic    not_found
);

  loc_t loc_a;
  loc_t loc_b;

  always_comb begin
    loc_a = first_hit(hits.hit_first);
    loc_b = first_hit(hits.hit_second);
    not_found    = !(loc_a.found && loc_b.found);
    plain_first  = '0;
    plain_second = '0;
    if (!not_found) begin
      if (loc_a.row == loc_b.row) begin
        plain_first  = cell_at(square, loc_a.row, dec_wrap(loc_a.col));
        plain_second = cell_at(square, loc_b.row, dec_wrap(loc_b.col));
      end else if (loc_a.col == loc_b.col) begin
        plain_first  = cell_at(square, dec_wrap(loc_a.row), loc_a.col);
        plain_second = cell_at(square, dec_wrap(loc_b.row), loc_b.col);
      end else begin
        plain_first  = cell_at(square, loc_a.row, loc_b.col);
        plain_second = cell_at(square, loc_b.row, loc_a.col);
      end
    end
  end

endmodule

[dv/playfair_digraph_decrypt_checker.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_checker
// Keeps a copy of the key square from the config port, works out the plaintext
// of every accepted digraph and compares it with the results in arrival order.
// ----------------------------------------------------------------------------
module playfair_digraph_decrypt_checker
  import pdd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0] cfg_data,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // cipher_first, cipher_second, zero pad
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [15:0]      m_axis_tdata,  // plain_first, plain_second, zero pad
  input  logic             m_axis_tuser,  // not_found
  output int               fail_count,
  output int               outstanding,
  output int               same_row_count,
  output int               same_col_count,
  output int               rect_count,
  output int               absent_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 20;

  typedef enum logic [1:0] {RULE_ROW, RULE_COL, RULE_RECT, RULE_ABSENT} rule_e;

  typedef struct packed {
    code_t first;
    code_t second;
    logic  absent;
  } plain_t;

  square_t key_square;
  plain_t  plain_q[$];
  int      n_fail;
  int      n_row;
  int      n_col;
  int      n_rect;
  int      n_absent;

  function automatic code_t square_cell(input square_t sq, input int r, input int c);
    return sq[r][c*CODE_W +: CODE_W];
  endfunction

  function automatic logic find_letter(input square_t sq, input code_t code,
                                       output int row, output int col);
    code_t wanted;
    logic  hit;
    wanted = (code == CODE_J) ? CODE_I : code;
    hit = 1'b0;
    row = 0;
    col = 0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (!hit && square_cell(sq, r, c) == wanted) begin
          hit = 1'b1;
          row = r;
          col = c;
        end
      end
    end
    return hit;
  endfunction

  function automatic plain_t decrypt_digraph(input square_t sq, input code_t a,
                                             input code_t b, output rule_e rule);
    int     r1, c1, r2, c2;
    logic   f1, f2;
    plain_t p;
    f1 = find_letter(sq, a, r1, c1);
    f2 = find_letter(sq, b, r2, c2);
    p = '0;
    if (!f1 || !f2) begin
      p.absent = 1'b1;
      rule = RULE_ABSENT;
    end else if (r1 == r2) begin
      p.first  = square_cell(sq, r1, (c1 + SIDE - 1) % SIDE);
      p.second = square_cell(sq, r2, (c2 + SIDE - 1) % SIDE);
      rule = RULE_ROW;
    end else if (c1 == c2) begin
      p.first  = square_cell(sq, (r1 + SIDE - 1) % SIDE, c1);
      p.second = square_cell(sq, (r2 + SIDE - 1) % SIDE, c2);
      rule = RULE_COL;
    end else begin
      p.first  = square_cell(sq, r1, c2);
      p.second = square_cell(sq, r2, c1);
      rule = RULE_RECT;
    end
    return p;
  endfunction

  always @(posedge clk) begin : watch
    plain_t want;
    plain_t got;
    rule_e  rule;
    if (rst) begin
      key_square = '0;
      plain_q.delete();
      n_fail = 0;
      n_row = 0;
      n_col = 0;
      n_rect = 0;
      n_absent = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.first  = m_axis_tdata[CODE_W-1:0];
        got.second = m_axis_tdata[2*CODE_W-1:CODE_W];
        got.absent = m_axis_tuser;
        if (plain_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: unexpected item: expected none, actual %0d %0d nf=%0b",
                     $time, got.first, got.second, got.absent);
        end else begin
          want = plain_q.pop_front();
          if (got.first !== want.first || got.second !== want.second ||
              got.absent !== want.absent) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display("%0t: mismatch: expected %0d %0d nf=%0b, actual %0d %0d nf=%0b",
                       $time, want.first, want.second, want.absent,
                       got.first, got.second, got.absent);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = decrypt_digraph(key_square, s_axis_tdata[CODE_W-1:0],
                               s_axis_tdata[2*CODE_W-1:CODE_W], rule);
        plain_q.push_back(want);
        case (rule)
          RULE_ROW:  n_row++;
          RULE_COL:  n_col++;
          RULE_RECT: n_rect++;
          default:   n_absent++;
        endcase
      end
      // indexes past the last row are ignored
      if (cfg_we && cfg_index < SIDE)
        key_square[cfg_index] = cfg_data;
    end
    fail_count     <= n_fail;
    outstanding    <= plain_q.size();
    same_row_count <= n_row;
    same_col_count <= n_col;
    rect_count     <= n_rect;
    absent_count   <= n_absent;
  end

endmodule

[dv/playfair_digraph_decrypt_top_test.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_top_test
// Drives ciphertext digraphs into the Playfair decrypter under a series of
// key squares (reset, classic, odd codes and duplicates, all ones, shuffled
// and noisy random squares) with random stalls on both streams; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module playfair_digraph_decrypt_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdd_pkg::*;

  localparam int LIMIT         = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 110;
  localparam logic [IDX_W-1:0] REG_SPARE = '1;

  // row 0 in the low bits
  localparam square_t ODD_SQUARE = {
    {5'd24, 5'd25, 5'd29, 5'd28, 5'd27},
    {5'd0,  5'd13, 5'd12, 5'd11, 5'd10},
    {5'd30, 5'd8,  5'd7,  5'd6,  5'd5},
    {5'd31, 5'd4,  5'd3,  5'd2,  5'd1},
    {5'd0,  5'd0,  5'd26, 5'd31, 5'd9}
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic             m_axis_tuser;

  int fail_count, outstanding;
  int same_row_count, same_col_count, rect_count, absent_count;
  int send_idle_pct = 22;
  int recv_idle_pct = 50;
  int squares_loaded = 0;
  int digraphs_sent = 0;
  int cycle_count = 0;

  playfair_digraph_decrypt_top DUT (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  playfair_digraph_decrypt_checker checker_i (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count, .outstanding, .same_row_count, .same_col_count,
    .rect_count, .absent_count
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_digraph(input code_t a, input code_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, b, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    digraphs_sent++;
  endtask

  // hold the sender until every result is back and the pipe is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_square(input square_t sq);
    drain();
    write_reg(REG_KEY_ROW_0, sq[0]);
    write_reg(REG_KEY_ROW_1, sq[1]);
    write_reg(REG_KEY_ROW_2, sq[2]);
    write_reg(REG_KEY_ROW_3, sq[3]);
    write_reg(REG_KEY_ROW_4, sq[4]);
    write_reg(REG_SPARE, ROW_W'($urandom));
    cfg_we <= 1'b0;
    squares_loaded++;
  endtask

  function automatic square_t square_from_text(input string text);
    square_t sq;
    sq = '0;
    for (int i = 0; i < CELLS; i++)
      sq[i / SIDE][(i % SIDE) * CODE_W +: CODE_W] = code_t'(text[i] - 8'd65);
    return sq;
  endfunction

  // shuffled alphabet without j, then some cells overwritten with any code
  function automatic square_t make_square(input int noise_cells);
    code_t   pool[CELLS];
    code_t   t;
    square_t sq;
    int      k, j, r, c;
    k = 0;
    for (int code = 0; code < 26; code++) begin
      if (code_t'(code) != CODE_J) begin
        pool[k] = code_t'(code);
        k++;
      end
    end
    for (int i = CELLS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int i = 0; i < CELLS; i++)
      sq[i / SIDE][(i % SIDE) * CODE_W +: CODE_W] = pool[i];
    for (int i = 0; i < noise_cells; i++) begin
      r = $urandom_range(0, SIDE - 1);
      c = $urandom_range(0, SIDE - 1);
      sq[r][c * CODE_W +: CODE_W] = code_t'($urandom);
    end
    return sq;
  endfunction

  task automatic send_random_digraph(input square_t sq);
    int    r1, c1, r2, c2, kind;
    code_t a, b;
    r1 = $urandom_range(0, SIDE - 1);
    c1 = $urandom_range(0, SIDE - 1);
    r2 = $urandom_range(0, SIDE - 1);
    c2 = $urandom_range(0, SIDE - 1);
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: r2 = r1;
      2, 3: c2 = c1;
      4: begin
        r2 = r1;
        c2 = c1;
      end
      default: ;
    endcase
    a = sq[r1][c1 * CODE_W +: CODE_W];
    b = sq[r2][c2 * CODE_W +: CODE_W];
    if (a == CODE_I && $urandom_range(0, 3) == 0) a = CODE_J;
    if (b == CODE_I && $urandom_range(0, 3) == 0) b = CODE_J;
    // noise: one or both letters anywhere in the code space
    if (kind >= 8) a = code_t'($urandom);
    if (kind == 9) b = code_t'($urandom);
    send_digraph(a, b);
  endtask

  initial begin
    square_t sq;
    string   pairs[$];
    int      noise_table[5];
    noise_table = '{0, 0, 3, 10, 25};
    pairs = '{"PF", "LY", "PT", "IK", "PZ", "AZ", "JR", "JJ", "EE", "ZA", "TZ",
              "XW", "IJ"};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset square: every cell holds a
    send_digraph(5'd0, 5'd0);
    send_digraph(5'd1, 5'd25);
    send_digraph(CODE_J, 5'd0);
    send_digraph(5'd31, 5'd0);
    squares_loaded++;

    load_square(square_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ"));
    foreach (pairs[i])
      send_digraph(code_t'(pairs[i][0] - 8'd65), code_t'(pairs[i][1] - 8'd65));
    send_digraph(5'd0, 5'd25);
    send_digraph(5'd31, 5'd31);
    send_digraph(5'd26, 5'd5);

    // j cell, codes above z, duplicates
    load_square(ODD_SQUARE);
    send_digraph(5'd31, 5'd26);
    send_digraph(5'd0, 5'd5);
    send_digraph(CODE_J, CODE_J);
    send_digraph(5'd30, 5'd24);
    send_digraph(5'd14, 5'd1);
    send_digraph(5'd27, 5'd25);
    send_digraph(CODE_I, 5'd31);

    load_square('1);
    send_digraph(5'd31, 5'd31);
    send_digraph(5'd31, 5'd0);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 50 : 0;
      recv_idle_pct = (mode == 0) ? 50 : (mode == 1) ? 22 : 0;
      for (int p = 0; p < 5; p++) begin
        sq = make_square(noise_table[p]);
        load_square(sq);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          if (n == PHASE_ITEMS / 2) drain();
          send_random_digraph(sq);
        end
      end
    end
    drain();

    $display("%0d digraphs under %0d key squares: %0d same row, %0d same column,",
             digraphs_sent, squares_loaded, same_row_count, same_col_count);
    $display("%0d rectangle, %0d with a letter missing; %0d mismatches",
             rect_count, absent_count, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
